// File: src/lles_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lles_pkg: shared constants and types of the eviction store
// Field widths, register reset value, opcodes and the directory command
// and status structs.
// ----------------------------------------------------------------------------
package lles_pkg;

    localparam int ID_W           = 10;
    localparam int CAP_W          = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam int NUM_IDS_DEF    = 1024;
    localparam int CAPACITY_DEF   = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int STAMP_BITS_DEF = 32;

    localparam int IN_TDATA_W     = 16;
    localparam int IN_TUSER_W     = 2;
    localparam int OUT_TDATA_W    = 16;
    localparam int OUT_TUSER_W    = 1;

    localparam logic OP_USE      = 1'b0;
    localparam logic OP_INSERT   = 1'b1;
    localparam logic POL_OLDEST  = 1'b0;
    localparam logic POL_FEWEST  = 1'b1;
    localparam logic OUT_MISS    = 1'b0;
    localparam logic OUT_EVICT   = 1'b1;

    typedef struct packed {
        logic rd;
        logic wr;
        logic resident;
    } t_dir_cmd;

    typedef struct packed {
        logic busy;
    } t_dir_stat;

endpackage

// File: src/lles_dir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lles_dir: id directory
// One synchronous memory holding, per id, a resident flag and its slot.
// Sweeps every entry to zero after reset, one entry per cycle.
// ----------------------------------------------------------------------------
module lles_dir #(
    parameter int NUM_IDS = lles_pkg::NUM_IDS_DEF,
    parameter int SLOT_W  = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lles_pkg::t_dir_cmd        i_cmd,
    input  logic [$clog2(NUM_IDS)-1:0] i_rd_addr,
    input  logic [$clog2(NUM_IDS)-1:0] i_wr_addr,
    input  logic [SLOT_W-1:0]         i_wr_slot,
    output logic                      o_rd_resident,
    output logic [SLOT_W-1:0]         o_rd_slot,
    output lles_pkg::t_dir_stat       o_stat
);

    localparam int IDX_W = $clog2(NUM_IDS);

    logic [SLOT_W:0]    r_mem [NUM_IDS];
    logic [SLOT_W:0]    r_rd_q;
    logic [IDX_W-1:0]   r_clr_ptr;
    logic               r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_ptr <= '0;
        end else if (r_busy) begin
            if (r_clr_ptr == IDX_W'(NUM_IDS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_ptr <= r_clr_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_ptr] <= '0;
        end else if (i_cmd.wr) begin
            r_mem[i_wr_addr] <= {i_cmd.resident, i_wr_slot};
        end
        if (i_cmd.rd) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_resident = r_rd_q[SLOT_W];
    assign o_rd_slot     = r_rd_q[SLOT_W-1:0];
    assign o_stat.busy   = r_busy;

endmodule

// File: src/lru_lfu_eviction_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_lfu_eviction_store: resident set of item ids with LRU / LFU eviction
// Tracks up to CAPACITY resident ids with a use count and a recency stamp.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one event per beat: tuser[0] opcode (use/insert),
//   tuser[1] policy, tdata[9:0] item id. Master stream returns a beat only
//   for a refused use (tuser 0) or an eviction (tuser 1), with the id in
//   tdata[9:0]. The cfg channel writes capacity_in_use; it is always ready
//   and must be written only while the block is idle.
//   One event at a time: a use goes from LOOKUP to USE_WR on a hit or to
//   POST on a miss, an insert with free room or of a resident id ends in
//   LOOKUP, and an insert into a full set goes on through SCAN, EVICT,
//   CLAIM and POST because the slot memory is scanned one slot per cycle
//   through its single read port. After reset all NUM_IDS entries of the
//   id directory (1024 by default) are swept to zero; no event is taken
//   until the sweep ends.
//   A held result stays in the output register while the master is stalled;
//   the next event is accepted meanwhile and waits for the register to free.
// ----------------------------------------------------------------------------
module lru_lfu_eviction_store #(
    parameter int NUM_IDS    = lles_pkg::NUM_IDS_DEF,
    parameter int CAPACITY   = lles_pkg::CAPACITY_DEF,
    parameter int COUNT_BITS = lles_pkg::COUNT_BITS_DEF,
    parameter int STAMP_BITS = lles_pkg::STAMP_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [lles_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // item_id, zero pad
    input  logic [lles_pkg::IN_TUSER_W-1:0]  i_s_tuser,   // opcode, policy
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [lles_pkg::OUT_TDATA_W-1:0] o_m_tdata,   // reported_item, zero pad
    output logic [lles_pkg::OUT_TUSER_W-1:0] o_m_tuser,   // outcome
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lles_pkg::CAP_W-1:0]       i_cfg_data
);

    localparam int ITEM_W = lles_pkg::ID_W;
    localparam int IDX_W  = $clog2(NUM_IDS);
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = ITEM_W + COUNT_BITS + STAMP_BITS;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_LOOKUP = 8'b0000_0100,
        S_USE_WR = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_EVICT  = 8'b0010_0000,
        S_CLAIM  = 8'b0100_0000,
        S_POST   = 8'b1000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [lles_pkg::CAP_W-1:0] r_cap;
    logic [CNT_W-1:0]           r_count;
    logic [STAMP_BITS-1:0]      r_clock;
    logic                       r_op, r_pol, r_valid_id;
    logic [ITEM_W-1:0]          r_id;
    logic [CNT_W-1:0]           r_ptr;
    logic [SLOT_W-1:0]          r_best_slot;
    logic [ITEM_W-1:0]          r_best_item;
    logic [COUNT_BITS-1:0]      r_best_uses;
    logic [STAMP_BITS-1:0]      r_best_stamp;
    logic                       r_res_kind;
    logic [ITEM_W-1:0]          r_res_item;
    logic                       r_out_valid;
    logic                       r_out_kind;
    logic [ITEM_W-1:0]          r_out_item;

    logic [WORD_W-1:0]          r_slot_mem [CAPACITY];
    logic [WORD_W-1:0]          r_slot_q;

    logic                       w_accept, w_hit, w_room, w_better, w_scan_last, w_out_free;
    logic [ITEM_W-1:0]          w_in_id;
    logic [ITEM_W+IDX_W-1:0]    w_in_ext, w_id_ext, w_vic_ext;
    logic [IDX_W-1:0]           w_in_idx, w_id_idx, w_vic_idx;
    logic [31:0]                w_eff;
    logic [CNT_W-1:0]           w_ptr_nx;
    logic [ITEM_W-1:0]          w_q_item;
    logic [COUNT_BITS-1:0]      w_q_uses, w_uses_inc;
    logic [STAMP_BITS-1:0]      w_q_stamp;

    lles_pkg::t_dir_cmd         w_dir_cmd;
    lles_pkg::t_dir_stat        w_dir_stat;
    logic [IDX_W-1:0]           w_dir_wr_addr;
    logic [SLOT_W-1:0]          w_dir_wr_slot;
    logic                       w_dir_resident;
    logic [SLOT_W-1:0]          w_dir_slot;

    logic                       w_slot_rd, w_slot_we;
    logic [SLOT_W-1:0]          w_slot_rd_addr, w_slot_wr_addr;
    logic [WORD_W-1:0]          w_slot_wd;

    lles_dir #(
        .NUM_IDS (NUM_IDS),
        .SLOT_W  (SLOT_W)
    ) u_dir (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_dir_cmd),
        .i_rd_addr     (w_in_idx),
        .i_wr_addr     (w_dir_wr_addr),
        .i_wr_slot     (w_dir_wr_slot),
        .o_rd_resident (w_dir_resident),
        .o_rd_slot     (w_dir_slot),
        .o_stat        (w_dir_stat)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;

    assign w_in_id   = i_s_tdata[ITEM_W-1:0];
    assign w_in_ext  = {{IDX_W{1'b0}}, w_in_id};
    assign w_id_ext  = {{IDX_W{1'b0}}, r_id};
    assign w_vic_ext = {{IDX_W{1'b0}}, r_best_item};
    assign w_in_idx  = w_in_ext[IDX_W-1:0];
    assign w_id_idx  = w_id_ext[IDX_W-1:0];
    assign w_vic_idx = w_vic_ext[IDX_W-1:0];

    always_comb begin
        if (r_cap == '0) begin
            w_eff = 32'd1;
        end else if (32'(r_cap) > 32'(CAPACITY)) begin
            w_eff = 32'(CAPACITY);
        end else begin
            w_eff = 32'(r_cap);
        end
    end

    assign w_room      = 32'(r_count) < w_eff;
    assign w_hit       = r_valid_id && w_dir_resident;
    assign w_ptr_nx    = r_ptr + 1'b1;
    assign w_scan_last = (r_ptr == r_count - 1'b1);

    assign w_q_item   = r_slot_q[WORD_W-1 -: ITEM_W];
    assign w_q_uses   = r_slot_q[STAMP_BITS +: COUNT_BITS];
    assign w_q_stamp  = r_slot_q[STAMP_BITS-1:0];
    assign w_uses_inc = (w_q_uses == '1) ? w_q_uses : w_q_uses + 1'b1;

    always_comb begin
        if (r_pol == lles_pkg::POL_FEWEST) begin
            w_better = (w_q_uses < r_best_uses) ||
                       ((w_q_uses == r_best_uses) && (w_q_stamp < r_best_stamp));
        end else begin
            w_better = w_q_stamp < r_best_stamp;
        end
    end

    always_comb begin
        n_state        = r_state;
        w_dir_cmd      = '0;
        w_dir_wr_addr  = w_id_idx;
        w_dir_wr_slot  = r_count[SLOT_W-1:0];
        w_slot_rd      = 1'b0;
        w_slot_rd_addr = w_dir_slot;
        w_slot_we      = 1'b0;
        w_slot_wr_addr = r_count[SLOT_W-1:0];
        w_slot_wd      = {r_id, {COUNT_BITS{1'b0}}, r_clock};
        unique case (r_state)
            S_CLEAR: begin
                if (!w_dir_stat.busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_dir_cmd.rd = w_accept;
                if (w_accept) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (r_op == lles_pkg::OP_USE) begin
                    if (w_hit) begin
                        w_slot_rd = 1'b1;
                        n_state   = S_USE_WR;
                    end else begin
                        n_state = S_POST;
                    end
                end else if (!r_valid_id || w_dir_resident) begin
                    n_state = S_IDLE;
                end else if (w_room) begin
                    w_slot_we              = 1'b1;
                    w_dir_cmd.wr           = 1'b1;
                    w_dir_cmd.resident     = 1'b1;
                    n_state                = S_IDLE;
                end else begin
                    w_slot_rd      = 1'b1;
                    w_slot_rd_addr = '0;
                    n_state        = S_SCAN;
                end
            end
            S_USE_WR: begin
                w_slot_we      = 1'b1;
                w_slot_wr_addr = w_dir_slot;
                w_slot_wd      = {w_q_item, w_uses_inc, r_clock};
                n_state        = S_IDLE;
            end
            S_SCAN: begin
                w_slot_rd      = 1'b1;
                w_slot_rd_addr = w_ptr_nx[SLOT_W-1:0];
                if (w_scan_last) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                w_slot_we      = 1'b1;
                w_slot_wr_addr = r_best_slot;
                w_dir_cmd.wr   = 1'b1;
                w_dir_wr_addr  = w_vic_idx;
                w_dir_wr_slot  = r_best_slot;
                n_state        = S_CLAIM;
            end
            S_CLAIM: begin
                w_dir_cmd.wr       = 1'b1;
                w_dir_cmd.resident = 1'b1;
                w_dir_wr_slot      = r_best_slot;
                n_state            = S_POST;
            end
            S_POST: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_mem[w_slot_wr_addr] <= w_slot_wd;
        end
        if (w_slot_rd) begin
            r_slot_q <= r_slot_mem[w_slot_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cap       <= lles_pkg::CAP_RESET;
            r_count     <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (w_accept && (r_clock != '1)) begin
                r_clock <= r_clock + 1'b1;
            end
            if ((r_state == S_LOOKUP) && (r_op == lles_pkg::OP_INSERT) && r_valid_id &&
                !w_dir_resident && w_room) begin
                r_count <= r_count + 1'b1;
            end
            if ((r_state == S_POST) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_s_tuser[0];
            r_pol      <= i_s_tuser[1];
            r_id       <= w_in_id;
            r_valid_id <= 32'(w_in_id) < 32'(NUM_IDS);
        end
        if ((r_state == S_LOOKUP) && (r_op == lles_pkg::OP_USE) && !w_hit) begin
            r_res_kind <= lles_pkg::OUT_MISS;
            r_res_item <= r_id;
        end
        if (r_state == S_LOOKUP) begin
            r_ptr <= '0;
        end
        if (r_state == S_SCAN) begin
            r_ptr <= w_ptr_nx;
            if ((r_ptr == '0) || w_better) begin
                r_best_slot  <= r_ptr[SLOT_W-1:0];
                r_best_item  <= w_q_item;
                r_best_uses  <= w_q_uses;
                r_best_stamp <= w_q_stamp;
            end
        end
        if (r_state == S_CLAIM) begin
            r_res_kind <= lles_pkg::OUT_EVICT;
            r_res_item <= r_best_item;
        end
        if ((r_state == S_POST) && w_out_free) begin
            r_out_kind <= r_res_kind;
            r_out_item <= r_res_item;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(lles_pkg::OUT_TDATA_W - ITEM_W){1'b0}}, r_out_item};
    assign o_m_tuser  = r_out_kind;

endmodule

// File: src/lles_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lles_check: port checker for the eviction store
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module lles_check (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [lles_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [lles_pkg::OUT_TUSER_W-1:0] o_m_tuser
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_tvalid && !o_s_tready)
        else $error("outputs active right after reset");

    a_one_event_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second event taken while one is in work");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result beat raised while idle");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result beat changed");

endmodule

bind lru_lfu_eviction_store lles_check u_lles_check (.*);
